>>> rtl/ising_pkg.sv
// ----------------------------------------------------------------------------
// ising_pkg
// Types and constants shared by the Ising lattice site update block.
// ----------------------------------------------------------------------------
package ising_pkg;

  localparam int SIDE_MAX   = 64;
  localparam int IDX_W      = 6;
  localparam int SIDE_W     = 7;
  localparam int THR_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int DE_W       = 5;

  typedef logic [SIDE_MAX-1:0] row_word_t;
  typedef logic [IDX_W-1:0]    idx_t;

  localparam logic [CFG_IDX_W-1:0] REG_LATTICE_SIDE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH_TWO    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH_FOUR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH_SIX    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH_EIGHT  = 3'd4;

  localparam logic signed [DE_W-1:0] DE_TWO   = 5'sd2;
  localparam logic signed [DE_W-1:0] DE_FOUR  = 5'sd4;
  localparam logic signed [DE_W-1:0] DE_SIX   = 5'sd6;
  localparam logic signed [DE_W-1:0] DE_EIGHT = 5'sd8;

  localparam logic [SIDE_W-1:0] SIDE_MIN_EFF = 7'd2;
  localparam logic [SIDE_W-1:0] SIDE_MAX_EFF = 7'd64;
  localparam logic [SIDE_W-1:0] SIDE_RESET   = 7'd64;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_TRIAL = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UP,
    ST_DN,
    ST_MID
  } upd_state_t;

endpackage

>>> rtl/ising_metropolis_site_update.sv
// ----------------------------------------------------------------------------
// ising_metropolis_site_update
// Metropolis single-site update on a square lattice of spins with open
// boundaries, with the lattice held one row per word in a synchronous memory.
//
//   channel   ports                               handshake
//   input     in_req_type .. in_random_value      start, taken when busy is low
//   result    out_accepted, out_spin_after, ...   out_valid, one cycle
//   config    cfg_index, cfg_wdata                cfg_we, no wait
//
// For every item, the row above, the row below and the site's own row are read
// in turn through the single read port of the row memory after acceptance, and
// the updated row is written back in the cycle that evaluates the trial; the
// result strobe is registered. A new item is taken on the cycle its
// predecessor's result is shown. Reset is synchronous and clears control and
// configuration; the row memory is not cleared, and every site must be
// loaded before a trial reads it. The receiver cannot stall the result.
// ----------------------------------------------------------------------------
module ising_metropolis_site_update
  import ising_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic                   in_req_type,
  input  logic [IDX_W-1:0]       in_row,
  input  logic [IDX_W-1:0]       in_col,
  input  logic                   in_spin_value,
  input  logic [THR_W-1:0]       in_random_value,
  output logic                   out_valid,
  output logic                   out_accepted,
  output logic                   out_spin_after,
  output logic signed [DE_W-1:0] out_delta_energy,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [THR_W-1:0]       cfg_wdata
);

  upd_state_t        state_r, state_nxt;
  logic [SIDE_W-1:0] lattice_side_r;
  logic [THR_W-1:0]  thr_two_r, thr_four_r, thr_six_r, thr_eight_r;

  logic              req_type_r;
  idx_t              row_r, col_r;
  logic              spin_value_r;
  logic [THR_W-1:0]  random_r;

  row_word_t         mem [SIDE_MAX];
  row_word_t         rd_data_r;
  idx_t              rd_addr;
  row_word_t         up_r, dn_r;
  logic              wr_en;
  row_word_t         wr_data;

  logic                   accept;
  logic [SIDE_W-1:0]      side_eff;
  logic                   in_range;
  logic                   up_ok, dn_ok, lf_ok, rt_ok;
  logic                   old_spin;
  logic [2:0]             n_cnt, p_cnt;
  logic signed [DE_W-1:0] sum_s, dbl_s, de_s;
  logic [THR_W-1:0]       thr_sel;
  logic                   acc;

  logic                   out_valid_r;
  logic                   out_accepted_r;
  logic                   out_spin_after_r;
  logic signed [DE_W-1:0] out_delta_energy_r;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lattice_side_r <= SIDE_RESET;
      thr_two_r      <= '0;
      thr_four_r     <= '0;
      thr_six_r      <= '0;
      thr_eight_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LATTICE_SIDE: lattice_side_r <= cfg_wdata[SIDE_W-1:0];
        REG_THRESH_TWO:   thr_two_r      <= cfg_wdata;
        REG_THRESH_FOUR:  thr_four_r     <= cfg_wdata;
        REG_THRESH_SIX:   thr_six_r      <= cfg_wdata;
        REG_THRESH_EIGHT: thr_eight_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    busy      = 1'b1;
    rd_addr   = row_r;
    case (state_r)
      ST_IDLE: begin
        busy    = !rst_n;
        rd_addr = in_row - idx_t'(1);
        if (accept) begin
          state_nxt = ST_UP;
        end
      end
      ST_UP: begin
        rd_addr   = row_r + idx_t'(1);
        state_nxt = ST_DN;
      end
      ST_DN: begin
        rd_addr   = row_r;
        state_nxt = ST_MID;
      end
      ST_MID: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_type_r   <= in_req_type;
      row_r        <= in_row;
      col_r        <= in_col;
      spin_value_r <= in_spin_value;
      random_r     <= in_random_value;
    end
    if (state_r == ST_UP) begin
      up_r <= rd_data_r;
    end
    if (state_r == ST_DN) begin
      dn_r <= rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
    if (wr_en) begin
      mem[row_r] <= wr_data;
    end
  end

  always_comb begin
    side_eff = lattice_side_r;
    if (lattice_side_r < SIDE_MIN_EFF) begin
      side_eff = SIDE_MIN_EFF;
    end else if (lattice_side_r > SIDE_MAX_EFF) begin
      side_eff = SIDE_MAX_EFF;
    end
    in_range = ({1'b0, row_r} < side_eff) && ({1'b0, col_r} < side_eff);
    up_ok    = (row_r != '0);
    dn_ok    = (({1'b0, row_r} + SIDE_W'(1)) < side_eff);
    lf_ok    = (col_r != '0);
    rt_ok    = (({1'b0, col_r} + SIDE_W'(1)) < side_eff);

    old_spin = rd_data_r[col_r];
    n_cnt = 3'(up_ok) + 3'(dn_ok) + 3'(lf_ok) + 3'(rt_ok);
    p_cnt = 3'(up_ok && up_r[col_r])
          + 3'(dn_ok && dn_r[col_r])
          + 3'(lf_ok && rd_data_r[col_r - idx_t'(1)])
          + 3'(rt_ok && rd_data_r[col_r + idx_t'(1)]);
    sum_s = $signed({1'b0, p_cnt, 1'b0}) - $signed({2'b00, n_cnt});
    dbl_s = $signed({sum_s[3:0], 1'b0});

    de_s = '0;
    if (req_type_r == REQ_TRIAL && spin_value_r != old_spin) begin
      de_s = old_spin ? dbl_s : -dbl_s;
    end

    case (de_s)
      DE_TWO:   thr_sel = thr_two_r;
      DE_FOUR:  thr_sel = thr_four_r;
      DE_SIX:   thr_sel = thr_six_r;
      DE_EIGHT: thr_sel = thr_eight_r;
      default:  thr_sel = '0;
    endcase

    acc = de_s[DE_W-1] || (de_s == '0) || (random_r < thr_sel);

    wr_en            = (state_r == ST_MID) && in_range && acc;
    wr_data          = rd_data_r;
    wr_data[col_r]   = spin_value_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == ST_MID);
    end
    if (state_r == ST_MID) begin
      if (in_range) begin
        out_accepted_r     <= acc;
        out_spin_after_r   <= acc ? spin_value_r : old_spin;
        out_delta_energy_r <= de_s;
      end else begin
        out_accepted_r     <= 1'b0;
        out_spin_after_r   <= 1'b0;
        out_delta_energy_r <= '0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_accepted     = out_accepted_r;
  assign out_spin_after   = out_spin_after_r;
  assign out_delta_energy = out_delta_energy_r;

endmodule
